// ----- rtl/core/ncpe_pkg.sv -----
// Shared types, constants and the microcode program of the composite pixel encoder.
// Used by ncpe_ctrl, ncpe_datapath and the top level; depends on nothing else.
`default_nettype none

package ncpe_pkg;

    // Multiplier operand and accumulator widths.
    localparam int A_W   = 35;
    localparam int B_W   = 18;
    localparam int P_W   = A_W + B_W;
    localparam int ACC_W = 56;
    localparam int H_W   = 32;

    // Filter history depths.
    localparam int LUMA_TAPS   = 7;
    localparam int CHROMA_TAPS = 4;

    // Program length of one rendered pixel.
    localparam int NSTEPS = 21;
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NSTEPS - 1);

    localparam logic [6:0] BLACK_LEVEL_RESET = 7'd10;
    localparam logic [6:0] LEVEL_MAX         = 7'd125;

    typedef enum logic [3:0] {
        A_ZERO, A_LY, A_LI, A_LQ,
        A_LY3, A_LY4, A_LY5, A_LY6,
        A_IY1, A_IY2, A_IY3,
        A_QY1, A_QY2, A_QY3,
        A_SIG
    } a_sel_t;

    typedef enum logic [1:0] {B_CONST, B_TAB_I, B_TAB_Q} b_sel_t;

    typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_op_t;

    typedef enum logic [3:0] {
        WB_NONE, WB_LX, WB_IX, WB_QX, WB_LY, WB_IY, WB_QY, WB_SIG, WB_OUT
    } wb_op_t;

    typedef enum logic [1:0] {FIR_NONE, FIR_L, FIR_I, FIR_Q} fir_op_t;

    // One datapath command: a multiply, an accumulator action on the product
    // registered in the previous cycle, a write-back and a feed-forward sum.
    typedef struct packed {
        a_sel_t                a_sel;
        b_sel_t                b_sel;
        logic signed [B_W-1:0] coef;
        acc_op_t               acc_op;
        wb_op_t                wb;
        fir_op_t               fir;
    } cmd_t;

    typedef struct packed {
        logic capture;
        cmd_t cmd;
    } ctl_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

    localparam cmd_t CMD_NOP = '{A_ZERO, B_CONST, '0, ACC_HOLD, WB_NONE, FIR_NONE};

    function automatic cmd_t mk(input a_sel_t a, input b_sel_t b,
                                input logic signed [B_W-1:0] c, input acc_op_t o,
                                input wb_op_t w, input fir_op_t f);
        cmd_t r;
        r.a_sel  = a;
        r.b_sel  = b;
        r.coef   = c;
        r.acc_op = o;
        r.wb     = w;
        r.fir    = f;
        return r;
    endfunction

    // Quadrature subcarrier weights in 1/4096 units.
    function automatic logic signed [B_W-1:0] chroma_weight(input logic [1:0] idx);
        logic signed [B_W-1:0] w;
        unique case (idx)
            2'd0: w = -18'sd2230;
            2'd1: w = -18'sd3435;
            2'd2: w = 18'sd2230;
            2'd3: w = 18'sd3435;
        endcase
        return w;
    endfunction

    // Microcode for one rendered pixel. The accumulator always acts on the
    // product of the previous step, so a LOAD or ADD lags its multiply.
    function automatic cmd_t step_cmd(input logic [STEP_W-1:0] step);
        cmd_t c;
        unique case (step)
            5'd0:  c = mk(A_LY,  B_CONST, 18'sd1897,   ACC_HOLD, WB_NONE, FIR_NONE);
            5'd1:  c = mk(A_LI,  B_CONST, 18'sd1413,   ACC_LOAD, WB_NONE, FIR_NONE);
            5'd2:  c = mk(A_LQ,  B_CONST, 18'sd75,     ACC_LOAD, WB_LX,   FIR_NONE);
            5'd3:  c = mk(A_LY3, B_CONST, -18'sd151,   ACC_LOAD, WB_IX,   FIR_NONE);
            5'd4:  c = mk(A_LY4, B_CONST, 18'sd8115,   ACC_LOAD, WB_QX,   FIR_NONE);
            5'd5:  c = mk(A_LY5, B_CONST, -18'sd38312, ACC_ADD,  WB_NONE, FIR_L);
            5'd6:  c = mk(A_LY6, B_CONST, 18'sd36586,  ACC_ADD,  WB_NONE, FIR_NONE);
            5'd7:  c = mk(A_IY1, B_CONST, 18'sd16559,  ACC_ADD,  WB_NONE, FIR_NONE);
            5'd8:  c = mk(A_IY2, B_CONST, -18'sd72008, ACC_LOAD, WB_LY,   FIR_NONE);
            5'd9:  c = mk(A_IY3, B_CONST, 18'sd109682, ACC_ADD,  WB_NONE, FIR_I);
            5'd10: c = mk(A_QY1, B_CONST, 18'sd2612,   ACC_ADD,  WB_NONE, FIR_NONE);
            5'd11: c = mk(A_QY2, B_CONST, -18'sd9007,  ACC_LOAD, WB_IY,   FIR_NONE);
            5'd12: c = mk(A_QY3, B_CONST, 18'sd10453,  ACC_ADD,  WB_NONE, FIR_Q);
            5'd13: c = mk(A_IY3, B_TAB_I, 18'sd0,      ACC_ADD,  WB_NONE, FIR_NONE);
            5'd14: c = mk(A_ZERO, B_CONST, 18'sd0,     ACC_LOAD, WB_QY,   FIR_NONE);
            5'd15: c = mk(A_QY3, B_TAB_Q, 18'sd0,      ACC_HOLD, WB_NONE, FIR_NONE);
            5'd16: c = mk(A_ZERO, B_CONST, 18'sd0,     ACC_ADD,  WB_NONE, FIR_NONE);
            5'd17: c = mk(A_ZERO, B_CONST, 18'sd0,     ACC_HOLD, WB_SIG,  FIR_NONE);
            5'd18: c = mk(A_SIG, B_CONST, 18'sd100,    ACC_HOLD, WB_NONE, FIR_NONE);
            5'd19: c = mk(A_ZERO, B_CONST, 18'sd0,     ACC_LOAD, WB_NONE, FIR_NONE);
            5'd20: c = mk(A_ZERO, B_CONST, 18'sd0,     ACC_HOLD, WB_OUT,  FIR_NONE);
            default: c = CMD_NOP;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ncpe_ctrl.sv -----
// Sequencer of the composite pixel encoder: accepts items and steps the microcode.
// Depends on ncpe_pkg.
`default_nettype none

module ncpe_ctrl
    import ncpe_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    input  wire logic       pixel_enable,
    output logic            s_tready,
    output ctl_cmd_t        ctl,
    input  wire dp_status_t status
);

    typedef enum logic {ST_IDLE, ST_RUN} state_t;

    state_t            state_reg;
    logic [STEP_W-1:0] step_reg;
    logic              accept;
    logic              stall;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    // The final write-back waits while the output register holds a result that is not being taken.
    assign stall    = (step_reg == LAST_STEP) && !status.out_free;

    always_comb begin
        ctl.capture = accept;
        ctl.cmd     = ((state_reg == ST_RUN) && !stall) ? step_cmd(step_reg) : CMD_NOP;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept && pixel_enable) begin
                        state_reg <= ST_RUN;
                        step_reg  <= '0;
                    end
                end
                ST_RUN: begin
                    if (!stall) begin
                        if (step_reg == LAST_STEP) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            step_reg <= step_reg + 1'b1;
                        end
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ncpe_datapath.sv -----
// Datapath of the composite pixel encoder: color sums, filter histories, shared MAC,
// black level register and output register. Depends on ncpe_pkg.
`default_nettype none

module ncpe_datapath
    import ncpe_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire ctl_cmd_t    ctl,
    output dp_status_t       status,
    input  wire logic [47:0] s_tdata,
    input  wire logic        line_start,
    input  wire logic [1:0]  column_phase,
    input  wire logic        black_level_we,
    input  wire logic [6:0]  black_level_wdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata
);

    logic [8:0] red_sum_reg, green_sum_reg, blue_sum_reg;
    logic [1:0] phase_reg;
    logic [6:0] black_level_reg;

    logic [H_W-1:0] lx_hist_reg [LUMA_TAPS];
    logic [H_W-1:0] ly_hist_reg [LUMA_TAPS];
    logic [H_W-1:0] ix_hist_reg [CHROMA_TAPS];
    logic [H_W-1:0] iy_hist_reg [CHROMA_TAPS];
    logic [H_W-1:0] qx_hist_reg [CHROMA_TAPS];
    logic [H_W-1:0] qy_hist_reg [CHROMA_TAPS];

    logic signed [P_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [H_W-1:0]          fir_reg;
    logic signed [A_W-1:0]   sig_reg;
    logic [6:0]              out_level_reg;
    logic                    out_valid_reg;

    logic signed [15:0] rs, gs, bs;
    logic signed [15:0] y_raw, i_raw, q_raw;
    logic signed [24:0] y_scaled, i_scaled, q_scaled;
    logic signed [15:0] ly_val, li_val, lq_val;
    logic signed [A_W-1:0] a_op;
    logic signed [B_W-1:0] b_op;
    logic signed [P_W-1:0] prod_comb;
    logic [H_W-1:0] fir_l, fir_i, fir_q, fir_s7, fir_s3;
    logic [H_W-1:0] x_new, y_new16, y_new12;
    logic signed [34:0] lvl_sum;
    logic [6:0] lvl_clamped;

    // Y, I and Q of the pixel pair, scaled by 257 and shifted down by 7.
    always_comb begin
        rs = 16'(signed'({1'b0, red_sum_reg}));
        gs = 16'(signed'({1'b0, green_sum_reg}));
        bs = 16'(signed'({1'b0, blue_sum_reg}));
        y_raw = 16'sd5 * rs + 16'sd11 * gs + 16'sd2 * bs;
        i_raw = 16'sd10 * rs - 16'sd4 * gs - 16'sd5 * bs;
        q_raw = 16'sd3 * rs - 16'sd8 * gs + 16'sd5 * bs;
        y_scaled = (25'(y_raw) <<< 8) + 25'(y_raw);
        i_scaled = (25'(i_raw) <<< 8) + 25'(i_raw);
        q_scaled = (25'(q_raw) <<< 8) + 25'(q_raw);
        ly_val = y_scaled[22:7];
        li_val = i_scaled[22:7];
        lq_val = q_scaled[22:7];
    end

    always_comb begin
        unique case (ctl.cmd.a_sel)
            A_ZERO:  a_op = '0;
            A_LY:    a_op = A_W'(ly_val);
            A_LI:    a_op = A_W'(li_val);
            A_LQ:    a_op = A_W'(lq_val);
            A_LY3:   a_op = A_W'(signed'(ly_hist_reg[3]));
            A_LY4:   a_op = A_W'(signed'(ly_hist_reg[4]));
            A_LY5:   a_op = A_W'(signed'(ly_hist_reg[5]));
            A_LY6:   a_op = A_W'(signed'(ly_hist_reg[6]));
            A_IY1:   a_op = A_W'(signed'(iy_hist_reg[1]));
            A_IY2:   a_op = A_W'(signed'(iy_hist_reg[2]));
            A_IY3:   a_op = A_W'(signed'(iy_hist_reg[3]));
            A_QY1:   a_op = A_W'(signed'(qy_hist_reg[1]));
            A_QY2:   a_op = A_W'(signed'(qy_hist_reg[2]));
            A_QY3:   a_op = A_W'(signed'(qy_hist_reg[3]));
            A_SIG:   a_op = sig_reg;
            default: a_op = '0;
        endcase
        unique case (ctl.cmd.b_sel)
            B_CONST: b_op = ctl.cmd.coef;
            B_TAB_I: b_op = chroma_weight(phase_reg);
            B_TAB_Q: b_op = chroma_weight(phase_reg - 2'd1);
            default: b_op = '0;
        endcase
    end

    assign prod_comb = a_op * b_op;

    // Feed-forward parts of the filters; sums wrap at 32 bits like the histories.
    always_comb begin
        fir_s7 = lx_hist_reg[2] + lx_hist_reg[4];
        fir_l  = lx_hist_reg[0] + lx_hist_reg[6]
               + ((lx_hist_reg[1] + lx_hist_reg[5]) << 2)
               + ((fir_s7 << 3) - fir_s7)
               + (lx_hist_reg[3] << 3);
        fir_s3 = ix_hist_reg[1] + ix_hist_reg[2];
        fir_i  = ix_hist_reg[0] + ix_hist_reg[3] + (fir_s3 << 1) + fir_s3;
        fir_q  = qx_hist_reg[0] + qx_hist_reg[3]
               + ((qx_hist_reg[1] + qx_hist_reg[2]) << 1)
               + (qx_hist_reg[1] + qx_hist_reg[2]);
    end

    always_comb begin
        x_new   = acc_reg[47:16];
        y_new16 = fir_reg + acc_reg[47:16];
        y_new12 = fir_reg + acc_reg[43:12];
        lvl_sum = 35'(signed'(acc_reg[47:14])) + 35'(signed'({1'b0, black_level_reg}));
        if (lvl_sum < 0) begin
            lvl_clamped = '0;
        end else if (lvl_sum > 35'(LEVEL_MAX)) begin
            lvl_clamped = LEVEL_MAX;
        end else begin
            lvl_clamped = lvl_sum[6:0];
        end
    end

    assign status.out_free = !out_valid_reg || m_tready;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = {1'b0, out_level_reg};

    // Payload registers without reset.
    always_ff @(posedge aclk) begin
        if (ctl.capture) begin
            red_sum_reg   <= {1'b0, s_tdata[7:0]}   + {1'b0, s_tdata[31:24]};
            green_sum_reg <= {1'b0, s_tdata[15:8]}  + {1'b0, s_tdata[39:32]};
            blue_sum_reg  <= {1'b0, s_tdata[23:16]} + {1'b0, s_tdata[47:40]};
            phase_reg     <= column_phase;
        end
        prod_reg <= prod_comb;
        unique case (ctl.cmd.acc_op)
            ACC_HOLD: acc_reg <= acc_reg;
            ACC_LOAD: acc_reg <= ACC_W'(prod_reg);
            ACC_ADD:  acc_reg <= acc_reg + ACC_W'(prod_reg);
            default:  acc_reg <= acc_reg;
        endcase
        unique case (ctl.cmd.fir)
            FIR_NONE: fir_reg <= fir_reg;
            FIR_L:    fir_reg <= fir_l;
            FIR_I:    fir_reg <= fir_i;
            FIR_Q:    fir_reg <= fir_q;
        endcase
        if (ctl.cmd.wb == WB_SIG) begin
            sig_reg <= A_W'(signed'(ly_hist_reg[LUMA_TAPS-1])) + signed'(acc_reg[46:12]);
        end
        if (ctl.cmd.wb == WB_OUT) begin
            out_level_reg <= lvl_clamped;
        end
    end

    // Filter histories: cleared by reset and by a line start, shifted on write-back.
    always_ff @(posedge aclk) begin
        if (!aresetn || (ctl.capture && line_start)) begin
            for (int i = 0; i < LUMA_TAPS; i++) begin
                lx_hist_reg[i] <= '0;
                ly_hist_reg[i] <= '0;
            end
            for (int i = 0; i < CHROMA_TAPS; i++) begin
                ix_hist_reg[i] <= '0;
                iy_hist_reg[i] <= '0;
                qx_hist_reg[i] <= '0;
                qy_hist_reg[i] <= '0;
            end
        end else begin
            unique case (ctl.cmd.wb)
                WB_LX: begin
                    for (int i = 0; i < LUMA_TAPS - 1; i++) lx_hist_reg[i] <= lx_hist_reg[i+1];
                    lx_hist_reg[LUMA_TAPS-1] <= x_new;
                end
                WB_LY: begin
                    for (int i = 0; i < LUMA_TAPS - 1; i++) ly_hist_reg[i] <= ly_hist_reg[i+1];
                    ly_hist_reg[LUMA_TAPS-1] <= y_new16;
                end
                WB_IX: begin
                    for (int i = 0; i < CHROMA_TAPS - 1; i++) ix_hist_reg[i] <= ix_hist_reg[i+1];
                    ix_hist_reg[CHROMA_TAPS-1] <= x_new;
                end
                WB_IY: begin
                    for (int i = 0; i < CHROMA_TAPS - 1; i++) iy_hist_reg[i] <= iy_hist_reg[i+1];
                    iy_hist_reg[CHROMA_TAPS-1] <= y_new16;
                end
                WB_QX: begin
                    for (int i = 0; i < CHROMA_TAPS - 1; i++) qx_hist_reg[i] <= qx_hist_reg[i+1];
                    qx_hist_reg[CHROMA_TAPS-1] <= x_new;
                end
                WB_QY: begin
                    for (int i = 0; i < CHROMA_TAPS - 1; i++) qy_hist_reg[i] <= qy_hist_reg[i+1];
                    qy_hist_reg[CHROMA_TAPS-1] <= y_new12;
                end
                default: begin
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg   <= 1'b0;
            black_level_reg <= BLACK_LEVEL_RESET;
        end else begin
            if (ctl.cmd.wb == WB_OUT) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (black_level_we) begin
                black_level_reg <= black_level_wdata;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ntsc_composite_pixel_encoder.sv -----
// Composite pixel encoder top level: one composite sample per rendered pixel pair.
// A rendered item's result is valid once the last microcode step writes it to the output register.
// A new item is taken only once the last one's microcode has finished, since the single
// shared multiplier runs all feedback filter taps, input scalings and the modulation in
// sequence; a masked item is taken while the block stays idle and produces no result.
// Reset (aresetn low, synchronous): filters cleared, black level 10, no result held.
`default_nettype none

module ntsc_composite_pixel_encoder
    import ncpe_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // Input pixel pair channel.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata from bit 0: red_a, green_a, blue_a, red_b, green_b, blue_b (8 bits each)
    input  wire logic [47:0] s_tdata,
    // tuser from bit 0: pixel_enable, line_start, column_phase[1:0]
    input  wire logic [3:0]  s_tuser,

    // Composite sample channel.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tdata from bit 0: composite_level[6:0], one zero pad bit
    output logic [7:0]       m_tdata,

    // Black level register, to be written only while the block is idle; the block does not enforce this.
    input  wire logic        black_level_we,
    input  wire logic [6:0]  black_level_wdata
);

    // The controller hands one command per cycle to the datapath and learns
    // from it whether the output register can take a new result.
    ctl_cmd_t   ctl;
    dp_status_t status;

    // The controller accepts an item whenever it is idle, even while the
    // previous result still waits in the output register; only the final
    // write-back of the next item waits for that transfer to complete.
    ncpe_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .pixel_enable (s_tuser[0]),
        .s_tready     (s_tready),
        .ctl          (ctl),
        .status       (status)
    );

    // The datapath holds the filter histories, the multiply-accumulate unit
    // and the output register. A line start clears the histories on the
    // transfer itself, masked pixel or not.
    ncpe_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .ctl               (ctl),
        .status            (status),
        .s_tdata           (s_tdata),
        .line_start        (s_tuser[1]),
        .column_phase      (s_tuser[3:2]),
        .black_level_we    (black_level_we),
        .black_level_wdata (black_level_wdata),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata)
    );

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the composite pixel encoder, top level only.
// Depends on ncpe_pkg and ntsc_composite_pixel_encoder; holds its own fixed-point filter model.

module tb;
    import ncpe_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 5;
    // Roughly 1700 items; the limit is many times what they take in the slowest case.
    localparam int CYCLE_LIMIT   = 500000;
    // Margin after draining; a masked pixel is done at its own transfer, so none stays in flight.
    localparam int DRAIN_CYCLES  = 30;
    localparam int PHASE_PIXELS  = 300;
    localparam int REPORT_LIMIT  = 10;

    // One pixel pair, laid out so that {tuser, tdata} is exactly this vector:
    // tdata holds the six color bytes (red_a lowest), tuser holds the flags and phase.
    typedef struct packed {
        logic [1:0] column_phase;
        logic       line_start;
        logic       pixel_enable;
        logic [7:0] blue_b;
        logic [7:0] green_b;
        logic [7:0] red_b;
        logic [7:0] blue_a;
        logic [7:0] green_a;
        logic [7:0] red_a;
    } pixel_t;

    logic        aclk              = 1'b0;
    logic        aresetn           = 1'b0;
    logic        s_tvalid          = 1'b0;
    wire         s_tready;
    logic [47:0] s_tdata           = '0;
    logic [3:0]  s_tuser           = '0;
    wire         m_tvalid;
    logic        m_tready          = 1'b0;
    wire  [7:0]  m_tdata;
    logic        black_level_we    = 1'b0;
    logic [6:0]  black_level_wdata = '0;

    // Stimulus waiting to be offered and composite levels waiting to come out.
    pixel_t     pending_pixels[$];
    logic [6:0] expected_levels[$];

    // Percentage of cycles in which each side holds back.
    int idle_pct = 10;

    int     queued_count      = 0;
    int     accepted_count    = 0;
    int     generated_renders = 0;
    int     rendered_count    = 0;
    int     masked_count      = 0;
    int     line_start_count  = 0;
    int     level_count       = 0;
    int     mismatch_count    = 0;
    int     clamp_low_count   = 0;
    int     clamp_high_count  = 0;
    longint cycle_count       = 0;

    // Model state: the black level register and the filter histories.
    // Each history is kept as a queue whose index 0 is the oldest entry.
    logic [6:0] black_level_model = BLACK_LEVEL_RESET;
    longint     luma_in[$];
    longint     luma_out[$];
    longint     inph_in[$];
    longint     inph_out[$];
    longint     quad_in[$];
    longint     quad_out[$];

    ntsc_composite_pixel_encoder dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tuser           (s_tuser),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .black_level_we    (black_level_we),
        .black_level_wdata (black_level_wdata)
    );

    always #CLK_HALF aclk = ~aclk;

    // ------------------------------------------------------------------
    // Encoder model
    // ------------------------------------------------------------------

    // Histories are stored as 32-bit two's complement words.
    function automatic longint to_h32(input longint v);
        logic signed [31:0] t;
        t = v[31:0];
        return t;
    endfunction

    // Subcarrier cosine weights in 1/4096 units, one per column phase.
    function automatic longint subcarrier_weight(input logic [1:0] ph);
        longint w;
        case (ph)
            2'd0:    w = -2230;
            2'd1:    w = -3435;
            2'd2:    w = 2230;
            default: w = 3435;
        endcase
        return w;
    endfunction

    function automatic void clear_filters();
        luma_in  = '{0, 0, 0, 0, 0, 0, 0};
        luma_out = '{0, 0, 0, 0, 0, 0, 0};
        inph_in  = '{0, 0, 0, 0};
        inph_out = '{0, 0, 0, 0};
        quad_in  = '{0, 0, 0, 0};
        quad_out = '{0, 0, 0, 0};
    endfunction

    // Steps the model by one accepted pixel pair. A masked pixel still honors
    // the line start clear but neither steps the filters nor yields a level.
    // All shifts below act on signed 64-bit values, so they round toward minus infinity.
    task automatic encode_pixel(input pixel_t p, output bit rendered, output logic [6:0] level);
        longint ra, ga, ba, rb, gb, bb;
        longint lum, inph, quad, acc, blk;
        logic [1:0] q_phase;
        if (p.line_start)
            clear_filters();
        rendered = p.pixel_enable;
        level = '0;
        if (!p.pixel_enable)
            return;

        ra = p.red_a;
        ga = p.green_a;
        ba = p.blue_a;
        rb = p.red_b;
        gb = p.green_b;
        bb = p.blue_b;
        blk = black_level_model;
        q_phase = p.column_phase - 2'd1;

        // The two rows are summed before the color-space weights are applied.
        lum  = ((5 * ra + 11 * ga + 2 * ba + 5 * rb + 11 * gb + 2 * bb) * 257) >>> 7;
        inph = ((10 * ra - 4 * ga - 5 * ba + 10 * rb - 4 * gb - 5 * bb) * 257) >>> 7;
        quad = ((3 * ra - 8 * ga + 5 * ba + 3 * rb - 8 * gb + 5 * bb) * 257) >>> 7;

        // Luma: feed-forward weights 1, 4, 7, 8, 7, 4, 1 over seven inputs and four feedback taps.
        luma_in.push_back(to_h32((lum * 1897) >>> 16));
        void'(luma_in.pop_front());
        acc = (luma_in[0] + luma_in[6]) + 4 * (luma_in[1] + luma_in[5])
            + 7 * (luma_in[2] + luma_in[4]) + 8 * luma_in[3]
            + ((-151 * luma_out[3] + 8115 * luma_out[4]
                - 38312 * luma_out[5] + 36586 * luma_out[6]) >>> 16);
        luma_out.push_back(to_h32(acc));
        void'(luma_out.pop_front());

        // In-phase chroma: three-pole low-pass.
        inph_in.push_back(to_h32((inph * 1413) >>> 16));
        void'(inph_in.pop_front());
        acc = (inph_in[0] + inph_in[3]) + 3 * (inph_in[1] + inph_in[2])
            + ((16559 * inph_out[1] - 72008 * inph_out[2] + 109682 * inph_out[3]) >>> 16);
        inph_out.push_back(to_h32(acc));
        void'(inph_out.pop_front());

        // Quadrature chroma: three-pole low-pass with a 12-bit feedback scale.
        quad_in.push_back(to_h32((quad * 75) >>> 16));
        void'(quad_in.pop_front());
        acc = (quad_in[0] + quad_in[3]) + 3 * (quad_in[1] + quad_in[2])
            + ((2612 * quad_out[1] - 9007 * quad_out[2] + 10453 * quad_out[3]) >>> 12);
        quad_out.push_back(to_h32(acc));
        void'(quad_out.pop_front());

        // Modulate, scale, offset by the black level and clamp.
        acc = luma_out[6] + ((subcarrier_weight(p.column_phase) * inph_out[3]
                              + subcarrier_weight(q_phase) * quad_out[3]) >>> 12);
        acc = ((acc * 100) >>> 14) + blk;
        if (acc < 0) begin
            level = '0;
            clamp_low_count++;
        end else if (acc > longint'(LEVEL_MAX)) begin
            level = LEVEL_MAX;
            clamp_high_count++;
        end else begin
            level = acc[6:0];
        end
    endtask

    // ------------------------------------------------------------------
    // Input driver: offers queued pixels and runs every accepted one
    // through the model at the edge where the transfer happens.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : drive_pixels
        bit         rendered;
        logic [6:0] level;
        pixel_t     next_pixel;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                accepted_count++;
                encode_pixel(pixel_t'({s_tuser, s_tdata}), rendered, level);
                if (rendered) begin
                    rendered_count++;
                    expected_levels.push_back(level);
                end else begin
                    masked_count++;
                end
                if (s_tuser[1])
                    line_start_count++;
            end
            // The offer is only changed once the current one has been taken,
            // so valid never drops while a transfer is pending.
            if (!s_tvalid || s_tready) begin
                if (pending_pixels.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    next_pixel = pending_pixels.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_pixel[47:0];
                    s_tuser  <= next_pixel[51:48];
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output monitor: random back-pressure, and every transfer is checked
    // against the oldest predicted level.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : check_levels
        logic [6:0] want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                level_count++;
                if (expected_levels.size() == 0) begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("%0t: level %0d arrived with none expected",
                                 $realtime, m_tdata[6:0]);
                    mismatch_count++;
                end else begin
                    want = expected_levels.pop_front();
                    if (m_tdata[6:0] !== want) begin
                        if (mismatch_count < REPORT_LIMIT)
                            $display("%0t: composite_level expected %0d, got %0d",
                                     $realtime, want, m_tdata[6:0]);
                        mismatch_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Guard against a hang: any run that gets this far has lost a transfer.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic queue_pixel(input logic [7:0] ra, input logic [7:0] ga, input logic [7:0] ba,
                               input logic [7:0] rb, input logic [7:0] gb, input logic [7:0] bb,
                               input bit en, input bit ls, input logic [1:0] ph);
        pixel_t p;
        p = '{column_phase: ph, line_start: ls, pixel_enable: en,
              blue_b: bb, green_b: gb, red_b: rb, blue_a: ba, green_a: ga, red_a: ra};
        pending_pixels.push_back(p);
        queued_count++;
        if (en)
            generated_renders++;
    endtask

    // Channel values lean toward the rails so that sharp edges and clamping show up.
    function automatic logic [7:0] random_channel();
        case ($urandom_range(9))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // A well-formed scan line: line start on the first pixel, column phase
    // advancing by one per pixel, colors often held so the filters settle,
    // and an occasional masked pixel.
    task automatic queue_random_line();
        int         len;
        logic [1:0] ph;
        logic [7:0] col [6];
        len = $urandom_range(48, 4);
        ph  = 2'($urandom_range(3));
        for (int i = 0; i < len; i++) begin
            if (i == 0 || $urandom_range(1) == 0)
                foreach (col[k]) col[k] = random_channel();
            queue_pixel(col[0], col[1], col[2], col[3], col[4], col[5],
                        $urandom_range(99) < 92, i == 0, ph);
            ph = ph + 2'd1;
        end
    endtask

    // Noise: every field random, including stray line starts and phase jumps.
    task automatic queue_noise_pixel();
        queue_pixel(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                    1'($urandom_range(1)), 1'($urandom_range(1)), 2'($urandom_range(3)));
    endtask

    // Waits until every queued pixel has been taken and every predicted level
    // has come out, then waits a further margin before returning.
    task automatic wait_drained();
        @(posedge aclk);
        while (accepted_count != queued_count || expected_levels.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Register writes only happen while the block is idle, so the model may
    // switch to the new level at once.
    task automatic write_black_level(input logic [6:0] v);
        @(posedge aclk);
        black_level_we    <= 1'b1;
        black_level_wdata <= v;
        @(posedge aclk);
        black_level_we    <= 1'b0;
        black_level_model = v;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : run_test
        logic [6:0] level;
        int         target;
        clear_filters();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset black level. Black, then a held white
        // so the luma filter climbs toward full scale.
        queue_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 2'd0);
        for (int ph = 1; ph < 4; ph++)
            queue_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0, 2'(ph));
        // Saturated red, green and blue, each as a fresh line over all four phases.
        for (int c = 0; c < 3; c++)
            for (int ph = 0; ph < 4; ph++)
                queue_pixel(c == 0 ? 8'd255 : 8'd0, c == 1 ? 8'd255 : 8'd0,
                            c == 2 ? 8'd255 : 8'd0, c == 0 ? 8'd255 : 8'd0,
                            c == 1 ? 8'd255 : 8'd0, c == 2 ? 8'd255 : 8'd0,
                            1'b1, ph == 0, 2'(ph));
        // Rows that differ: white over black, and complementary colors.
        queue_pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0, 2'd0);
        queue_pixel(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 1'b1, 1'b0, 2'd1);
        // A masked pixel leaves the filters alone; a masked one with a line
        // start still clears them, which the following pixel reveals.
        queue_pixel(8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 1'b0, 1'b0, 2'd2);
        queue_pixel(8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 1'b0, 1'b1, 2'd3);
        queue_pixel(8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 1'b1, 1'b0, 2'd0);
        wait_drained();

        // Random part in phases, each under its own black level: both
        // extremes, one just above the clamp and two random ones. The middle
        // phase runs with no idling on either side.
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0:       level = 7'd0;
                1:       level = 7'd127;
                3:       level = 7'd126;
                default: level = 7'($urandom_range(127));
            endcase
            idle_pct = (phase == 2) ? 0 : 10;
            write_black_level(level);
            target = generated_renders + PHASE_PIXELS;
            while (generated_renders < target) begin
                if ($urandom_range(9) == 0)
                    queue_noise_pixel();
                else
                    queue_random_line();
            end
            wait_drained();
        end

        $display("Covered %0d rendered and %0d masked pixels over %0d lines, six black levels.",
                 rendered_count, masked_count, line_start_count);
        $display("Checked %0d composite samples; %0d clamped low, %0d clamped high, %0d bad.",
                 level_count, clamp_low_count, clamp_high_count, mismatch_count);
        if (mismatch_count == 0 && expected_levels.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
